### sv/sprite_tile_expander_core_assert.svh
// Assertion macros for the sprite tile expander RTL.
`ifndef SPRITE_TILE_EXPANDER_CORE_ASSERT_SVH
`define SPRITE_TILE_EXPANDER_CORE_ASSERT_SVH

`ifndef SYNTH
// Checked at every rising edge of clk while rst_n is high.
`define STE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Checked at every rising edge of clk, reset included.
`define STE_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define STE_ASSERT(lbl, prop, msg)
`define STE_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

### sv/ste_pkg.sv
// Types and constants for the sprite tile expander.
package ste_pkg;

  localparam int InWidth     = 48;
  localparam int OutWidth    = 48;
  localparam int QueueDepth  = 2;

  localparam logic [15:0] PalMask   = 16'h7e00;
  localparam logic [15:0] PrioMask  = 16'h3000;
  localparam logic [5:0]  HighPal   = 6'h38;
  localparam logic [7:0]  YFlip     = 8'd240;
  localparam logic [15:0] XMask     = 16'h01ff;
  localparam logic [9:0]  XBias     = 10'h00f;
  localparam logic [15:0] SubMask   = 16'h0003;
  localparam int          SizeBit   = 11;
  localparam int          FlipXBit  = 14;
  localparam int          FlipYBit  = 15;

  // Decoded sprite, one queue entry.
  typedef struct packed {
    logic [17:0] code_base;  // bits 1:0 already cleared for a 2x2 block
    logic [5:0]  palette;
    logic        flip_x;
    logic        flip_y;
    logic [9:0]  sx_base;    // x - 15, two's complement
    logic [7:0]  y_base;     // (240 - y) mod 256
    logic [1:0]  prio;
    logic        single;
  } ste_desc_t;

  // One tile draw command.
  typedef struct packed {
    logic        high_layer;
    logic [1:0]  priority_res;
    logic [8:0]  screen_y;
    logic [9:0]  screen_x;
    logic        flip_y;
    logic        flip_x;
    logic [5:0]  palette;
    logic [17:0] tile_code;
  } ste_cmd_t;

endpackage

### sv/ste_front.sv
// Front end: takes a sprite record apart into a queue descriptor.
module ste_front (
  input  logic [15:0]       attr_word,
  input  logic [15:0]       position_word,
  input  logic [15:0]       code_word,
  output ste_pkg::ste_desc_t desc
);

  logic [15:0] pal_bits;
  logic [15:0] prio_bits;
  logic [15:0] x_bits;
  logic [15:0] sub_bits;
  logic [17:0] code_full;
  logic        single;

  always_comb begin
    pal_bits  = position_word & ste_pkg::PalMask;
    prio_bits = attr_word & ste_pkg::PrioMask;
    x_bits    = position_word & ste_pkg::XMask;
    sub_bits  = code_word & ste_pkg::SubMask;
    single    = attr_word[ste_pkg::SizeBit];
    code_full = {sub_bits[1:0], code_word};
    if (!single) begin
      code_full[1:0] = 2'b00;
    end

    desc.code_base = code_full;
    desc.palette   = pal_bits[14:9];
    desc.flip_x    = attr_word[ste_pkg::FlipXBit];
    desc.flip_y    = attr_word[ste_pkg::FlipYBit];
    desc.sx_base   = x_bits[9:0] - ste_pkg::XBias;
    desc.y_base    = ste_pkg::YFlip - attr_word[7:0];
    desc.prio      = prio_bits[13:12];
    desc.single    = single;
  end

endmodule

### sv/ste_queue.sv
// Small first-word-fall-through queue of sprite descriptors.
module ste_queue #(
  parameter int DEPTH = ste_pkg::QueueDepth
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  ste_pkg::ste_desc_t push_desc,
  output logic               full,
  input  logic               pop,
  output logic               valid,
  output ste_pkg::ste_desc_t head
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(DEPTH);

  ste_pkg::ste_desc_t mem_r [DEPTH];
  logic [PtrW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PtrW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CntW-1:0] count_r, count_nxt;
  logic            do_push;
  logic            do_pop;

  always_comb begin
    full       = (count_r == FullCnt);
    valid      = (count_r != '0);
    head       = mem_r[rd_ptr_r];
    do_push    = push && !full;
    do_pop     = pop && valid;
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == LastPtr) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LastPtr) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_desc;
    end
  end

endmodule

### sv/ste_back.sv
// Back end: walks the tiles of the head sprite into the output register.
`include "sprite_tile_expander_core_assert.svh"

module ste_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_valid,
  input  ste_pkg::ste_desc_t q_desc,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_ready,
  output ste_pkg::ste_cmd_t  out_cmd,
  output logic               out_last
);

  logic [1:0]        idx_r, idx_nxt;
  logic              out_valid_r, out_valid_nxt;
  ste_pkg::ste_cmd_t cmd_r, cmd_nxt;
  logic              last_r, last_nxt;
  logic              load;
  logic              col;
  logic              row;
  logic              tile_last;

  always_comb begin
    load      = !out_valid_r || out_ready;
    col       = idx_r[0];
    row       = idx_r[1];
    tile_last = q_desc.single || (idx_r == 2'd3);

    cmd_nxt.tile_code = q_desc.code_base;
    if (!q_desc.single) begin
      // 2x2 block: column steps the code by 2, row by 1, both mirrored by flip
      cmd_nxt.tile_code[1:0] = {col ^ q_desc.flip_x, row ^ q_desc.flip_y};
    end
    cmd_nxt.palette      = q_desc.palette;
    cmd_nxt.flip_x       = q_desc.flip_x;
    cmd_nxt.flip_y       = q_desc.flip_y;
    cmd_nxt.screen_x     = q_desc.sx_base + {6'd0, col, 3'b000};
    cmd_nxt.screen_y     = {1'b0, q_desc.y_base} + {5'd0, row, 3'b000};
    cmd_nxt.priority_res = q_desc.prio;
    cmd_nxt.high_layer   = (q_desc.palette >= ste_pkg::HighPal);
    last_nxt             = tile_last;

    q_pop         = load && q_valid && tile_last;
    out_valid_nxt = load ? q_valid : out_valid_r;
    idx_nxt       = idx_r;
    if (load && q_valid) begin
      idx_nxt = tile_last ? 2'd0 : idx_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load && q_valid) begin
      cmd_r  <= cmd_nxt;
      last_r <= last_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_cmd   = cmd_r;
  assign out_last  = last_r;

  // a sprite in mid-expansion stays at the queue head
  `STE_ASSERT(a_mid_has_head, (idx_r != 2'd0) |-> q_valid, "tile walk without queued sprite")
  // only 2x2 blocks ever advance the tile counter
  `STE_ASSERT(a_idx_block_only, (idx_r != 2'd0) |-> !q_desc.single, "single sprite past tile 0")
  // a single-tile sprite produces exactly one command, marked last
  `STE_ASSERT(a_single_last, (load && q_valid && q_desc.single) |=> (out_valid_r && last_r),
              "single sprite command not marked last")
  // the final tile of a block releases its queue entry
  `STE_ASSERT(a_block_pop, (load && q_valid && idx_r == 2'd3) |-> q_pop,
              "block finished without pop")

endmodule

### sv/sprite_tile_expander_core.sv
// Top level of the sprite tile expander: front decode, descriptor queue, tile walker.
//
//  channel | dir | tdata fields (low bit up)                                | tuser | tlast
//  in_     | in  | attr_word, position_word, code_word                      | -     | -
//  out_    | out | tile_code, palette, flip_x, flip_y, screen_x, screen_y,   | -     | last
//          |     | priority_res, high_layer                                 |       |
//
// The tile walker emits four commands for a 2x2 sprite and one for a single-tile sprite,
// one command per cycle into the output register while out_tready does not stall it.
// A request reaches its first command through a queue entry and then the output register.
// rst_n is synchronous, active low; it empties the queue and the output register.
// in_tready falls only when the descriptor queue is full; out_tready stalls the walker alone.
module sprite_tile_expander_core #(
  parameter int QUEUE_DEPTH = ste_pkg::QueueDepth
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_tvalid,
  output logic                         in_tready,
  input  logic [ste_pkg::InWidth-1:0]  in_tdata,   // attr_word, position_word, code_word
  output logic                         out_tvalid,
  input  logic                         out_tready,
  output logic [ste_pkg::OutWidth-1:0] out_tdata,  // tile_code, palette, flip_x, flip_y,
                                                   // screen_x, screen_y, priority_res,
                                                   // high_layer
  output logic                         out_tlast
);

  ste_pkg::ste_desc_t front_desc;
  ste_pkg::ste_desc_t head_desc;
  ste_pkg::ste_cmd_t  cmd;
  logic               q_full;
  logic               q_valid;
  logic               q_pop;

  ste_front u_front (
    .attr_word     (in_tdata[15:0]),
    .position_word (in_tdata[31:16]),
    .code_word     (in_tdata[47:32]),
    .desc          (front_desc)
  );

  ste_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_tvalid),
    .push_desc (front_desc),
    .full      (q_full),
    .pop       (q_pop),
    .valid     (q_valid),
    .head      (head_desc)
  );

  ste_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_desc    (head_desc),
    .q_pop     (q_pop),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_cmd   (cmd),
    .out_last  (out_tlast)
  );

  assign in_tready = !q_full;
  assign out_tdata = cmd;

endmodule
